>>> src/tti_pkg.sv
// Shared types, constants and codes of the trapezoid target integrator.
`default_nettype none

package tti_pkg;

    // Data and port widths
    localparam int DATA_BITS_DEF = 32;
    localparam int IO_BITS       = 32;
    localparam int COEF_BITS     = 16;
    localparam int COEF_FRAC     = 14;
    localparam int MUL_BITS      = 32;
    localparam int PROD_BITS     = 2 * MUL_BITS;
    localparam int ANG_PROD_BITS = IO_BITS + COEF_BITS - 1;
    localparam int ANG_Q_BITS    = ANG_PROD_BITS - COEF_FRAC;
    localparam int ADDR_BITS     = 5;
    localparam int REG_IDX_BITS  = 3;

    localparam logic [PROD_BITS-1:0] ANG_HALF = PROD_BITS'(1) << (COEF_FRAC - 1);

    // Register reset values
    localparam logic [COEF_BITS-1:0] COS_RESET       = 16'h4000;
    localparam logic [COEF_BITS-1:0] SIN_RESET       = 16'h0000;
    localparam logic [IO_BITS-1:0]   HALF_STEP_RESET = 32'd4294967;

    // Register map, byte address is four times the index
    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_COS_ANGLE = 3'd0,
        REG_SIN_ANGLE = 3'd1,
        REG_HALF_STEP = 3'd2,
        REG_START_X   = 3'd3,
        REG_START_Y   = 3'd4,
        REG_START_Z   = 3'd5
    } t_reg_idx;

    // Datapath operations, one per controller step
    typedef enum logic [3:0] {
        OP_IDLE,
        OP_ANG_MUL,
        OP_ANG_FIN,
        OP_FIRST,
        OP_VEL_PREP,
        OP_POS_PREP,
        OP_MUL_LO,
        OP_MUL_HI,
        OP_VEL_FIN,
        OP_POS_FIN
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   load_in;
        logic   load_out;
    } t_dp_cmd;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_ANG_MUL,
        S_ANG_FIN,
        S_FIRST,
        S_VEL_PREP,
        S_VEL_LO,
        S_VEL_HI,
        S_VEL_FIN,
        S_POS_PREP,
        S_POS_LO,
        S_POS_HI,
        S_POS_FIN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [COEF_BITS-1:0] cos_angle;
        logic [COEF_BITS-1:0] sin_angle;
        logic [IO_BITS-1:0]   half_step;
        logic [IO_BITS-1:0]   start_x;
        logic [IO_BITS-1:0]   start_y;
        logic [IO_BITS-1:0]   start_z;
    } t_cfg;

    typedef struct packed {
        logic [IO_BITS-1:0] pos_x;
        logic [IO_BITS-1:0] pos_y;
        logic [IO_BITS-1:0] pos_z;
        logic [IO_BITS-1:0] vel_x;
        logic [IO_BITS-1:0] vel_y;
        logic [IO_BITS-1:0] acc_x;
        logic [IO_BITS-1:0] acc_y;
    } t_result;

endpackage

`default_nettype wire

>>> src/tti_if.sv
// Valid/ready channel interfaces for command items and target items.
`default_nettype none

interface tti_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] accel_cmd;

    modport source (output valid, output accel_cmd, input ready);
    modport sink   (input valid, input accel_cmd, output ready);
endinterface

interface tti_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] acc_x;
    logic signed [31:0] acc_y;

    modport source (output valid, output pos_x, output pos_y, output pos_z,
                    output vel_x, output vel_y, output acc_x, output acc_y,
                    input ready);
    modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                    input vel_x, input vel_y, input acc_x, input acc_y,
                    output ready);
endinterface

`default_nettype wire

>>> src/tti_regs.sv
// APB configuration registers: plane angle, time step and start position.
`default_nettype none

module tti_regs
    import tti_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [ADDR_BITS-1:0] paddr,
    input  wire logic [IO_BITS-1:0]   pwdata,
    output logic      [IO_BITS-1:0]   prdata,
    output logic                      pready,
    output t_cfg                      o_cfg
);

    t_cfg                    r_cfg;
    logic                    wr_en;
    logic [REG_IDX_BITS-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[ADDR_BITS-1:2];
    assign o_cfg   = r_cfg;

    // Write the addressed register, drop writes beyond the map
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cos_angle <= COS_RESET;
            r_cfg.sin_angle <= SIN_RESET;
            r_cfg.half_step <= HALF_STEP_RESET;
            r_cfg.start_x   <= '0;
            r_cfg.start_y   <= '0;
            r_cfg.start_z   <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_COS_ANGLE: r_cfg.cos_angle <= pwdata[COEF_BITS-1:0];
                REG_SIN_ANGLE: r_cfg.sin_angle <= pwdata[COEF_BITS-1:0];
                REG_HALF_STEP: r_cfg.half_step <= pwdata;
                REG_START_X:   r_cfg.start_x   <= pwdata;
                REG_START_Y:   r_cfg.start_y   <= pwdata;
                REG_START_Z:   r_cfg.start_z   <= pwdata;
                default: ;
            endcase
        end
    end

    // Read back, angles sign-extended
    always_comb begin
        unique case (reg_idx)
            REG_COS_ANGLE: prdata = {{(IO_BITS-COEF_BITS){r_cfg.cos_angle[COEF_BITS-1]}},
                                     r_cfg.cos_angle};
            REG_SIN_ANGLE: prdata = {{(IO_BITS-COEF_BITS){r_cfg.sin_angle[COEF_BITS-1]}},
                                     r_cfg.sin_angle};
            REG_HALF_STEP: prdata = r_cfg.half_step;
            REG_START_X:   prdata = r_cfg.start_x;
            REG_START_Y:   prdata = r_cfg.start_y;
            REG_START_Z:   prdata = r_cfg.start_z;
            default:       prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

>>> src/tti_lane.sv
// One axis of the integrator: projection, trapezoid steps and saturation.
`default_nettype none

module tti_lane
    import tti_pkg::*;
#(
    parameter int DATA_BITS = DATA_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire t_dp_op               i_op,
    input  wire logic [IO_BITS-1:0]   i_a_mag,
    input  wire logic                 i_a_neg,
    input  wire logic [COEF_BITS-1:0] i_coef,
    input  wire logic [IO_BITS-1:0]   i_half_step,
    input  wire logic [IO_BITS-1:0]   i_start,
    output logic      [IO_BITS-1:0]   o_acc,
    output logic      [IO_BITS-1:0]   o_vel,
    output logic      [IO_BITS-1:0]   o_pos
);

    // Width of a sum's magnitude, of its part above the multiplier width, and of working sums
    localparam int MW = (DATA_BITS + 1 > MUL_BITS + 1) ? DATA_BITS + 1 : MUL_BITS + 1;
    localparam int HW = MW - MUL_BITS;
    localparam int TW = (DATA_BITS + 3 > ANG_Q_BITS + 1) ? DATA_BITS + 3 : ANG_Q_BITS + 1;

    logic [PROD_BITS-1:0] r_prod, n_prod;
    logic [MUL_BITS-1:0]  r_round, n_round;
    logic [MW-1:0]        r_mag, n_mag;
    logic                 r_neg, n_neg;
    logic [DATA_BITS-1:0] r_acc_new, n_acc_new;
    logic [DATA_BITS-1:0] r_vel_new, n_vel_new;
    logic [DATA_BITS-1:0] r_acc, n_acc;
    logic [DATA_BITS-1:0] r_vel, n_vel;
    logic [DATA_BITS-1:0] r_pos, n_pos;

    logic                 c_neg;
    logic [COEF_BITS-1:0] c_mag;
    logic [MUL_BITS-1:0]  mul_a, mul_b;
    logic [PROD_BITS-1:0] mul_p;
    logic [PROD_BITS-1:0] ang_sum;
    logic [TW-1:0]        ang_q, ang_val;
    logic [TW-1:0]        prep_a, prep_b, prep_s, prep_ns;
    logic [TW-1:0]        step, fin_base, fin_sum;
    logic [TW-1:0]        start_ext;

    function automatic logic [TW-1:0] sext_dw(input logic [DATA_BITS-1:0] v);
        sext_dw = {{(TW-DATA_BITS){v[DATA_BITS-1]}}, v};
    endfunction

    function automatic logic [DATA_BITS-1:0] sat_dw(input logic [TW-1:0] v);
        logic [TW-DATA_BITS:0] top;
        top = v[TW-1:DATA_BITS-1];
        if ((&top) || !(|top)) begin
            sat_dw = v[DATA_BITS-1:0];
        end else if (v[TW-1]) begin
            sat_dw = {1'b1, {(DATA_BITS-1){1'b0}}};
        end else begin
            sat_dw = {1'b0, {(DATA_BITS-1){1'b1}}};
        end
    endfunction

    function automatic logic [IO_BITS-1:0] to_io(input logic [DATA_BITS-1:0] v);
        logic [TW-1:0] ext;
        ext   = sext_dw(v);
        to_io = ext[IO_BITS-1:0];
    endfunction

    // Coefficient magnitude and sign
    assign c_neg = i_coef[COEF_BITS-1];
    assign c_mag = c_neg ? (~i_coef + COEF_BITS'(1)) : i_coef;

    // Select multiplier operands
    always_comb begin
        unique case (i_op)
            OP_ANG_MUL: begin
                mul_a = i_a_mag;
                mul_b = {{(MUL_BITS-COEF_BITS){1'b0}}, c_mag};
            end
            OP_MUL_HI: begin
                mul_a = {{(MUL_BITS-HW){1'b0}}, r_mag[MW-1:MUL_BITS]};
                mul_b = i_half_step;
            end
            default: begin
                mul_a = r_mag[MUL_BITS-1:0];
                mul_b = i_half_step;
            end
        endcase
    end

    assign mul_p = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);

    // Round the projected product to Q16.16
    assign ang_sum = r_prod + ANG_HALF;
    assign ang_q   = {{(TW-ANG_Q_BITS){1'b0}}, ang_sum[ANG_PROD_BITS-1:COEF_FRAC]};
    assign ang_val = r_neg ? (TW'(0) - ang_q) : ang_q;

    // Sum of old and new value, taken apart into sign and magnitude
    assign prep_a  = (i_op == OP_POS_PREP) ? sext_dw(r_vel) : sext_dw(r_acc);
    assign prep_b  = (i_op == OP_POS_PREP) ? sext_dw(r_vel_new) : sext_dw(r_acc_new);
    assign prep_s  = prep_a + prep_b;
    assign prep_ns = TW'(0) - prep_a - prep_b;

    // Rounded step magnitude: high partial product plus rounded low half
    assign step     = {{(TW-MW){1'b0}}, r_prod[MW-1:0]}
                    + {{(TW-MUL_BITS){1'b0}}, r_round};
    assign fin_base = (i_op == OP_POS_FIN) ? sext_dw(r_pos) : sext_dw(r_vel);
    assign fin_sum  = r_neg ? (fin_base - step) : (fin_base + step);

    assign start_ext = {{(TW-IO_BITS){i_start[IO_BITS-1]}}, i_start};

    // Advance the lane by one operation
    always_comb begin
        n_prod    = r_prod;
        n_round   = r_round;
        n_mag     = r_mag;
        n_neg     = r_neg;
        n_acc_new = r_acc_new;
        n_vel_new = r_vel_new;
        n_acc     = r_acc;
        n_vel     = r_vel;
        n_pos     = r_pos;
        unique case (i_op)
            OP_ANG_MUL: begin
                n_prod = mul_p;
                n_neg  = i_a_neg ^ c_neg;
            end
            OP_ANG_FIN: begin
                n_acc_new = sat_dw(ang_val);
            end
            OP_FIRST: begin
                n_acc = r_acc_new;
                n_vel = '0;
                n_pos = sat_dw(start_ext);
            end
            OP_VEL_PREP, OP_POS_PREP: begin
                n_neg = prep_s[TW-1];
                n_mag = prep_s[TW-1] ? prep_ns[MW-1:0] : prep_s[MW-1:0];
            end
            OP_MUL_LO: begin
                n_prod = mul_p;
            end
            OP_MUL_HI: begin
                n_prod  = mul_p;
                n_round = r_prod[PROD_BITS-1:MUL_BITS]
                        + {{(MUL_BITS-1){1'b0}}, r_prod[MUL_BITS-1]};
            end
            OP_VEL_FIN: begin
                n_vel_new = sat_dw(fin_sum);
            end
            OP_POS_FIN: begin
                n_acc = r_acc_new;
                n_vel = r_vel_new;
                n_pos = sat_dw(fin_sum);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod    <= n_prod;
        r_round   <= n_round;
        r_mag     <= n_mag;
        r_neg     <= n_neg;
        r_acc_new <= n_acc_new;
        r_vel_new <= n_vel_new;
        r_acc     <= n_acc;
        r_vel     <= n_vel;
        r_pos     <= n_pos;
    end

    assign o_acc = to_io(r_acc);
    assign o_vel = to_io(r_vel);
    assign o_pos = to_io(r_pos);

endmodule

`default_nettype wire

>>> src/tti_dp.sv
// Datapath: input register, x and y lanes, and the output register.
`default_nettype none

module tti_dp
    import tti_pkg::*;
#(
    parameter int DATA_BITS = DATA_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire t_dp_cmd            i_cmd,
    input  wire t_cfg               i_cfg,
    input  wire logic [IO_BITS-1:0] i_accel_cmd,
    output t_result                 o_res
);

    logic [IO_BITS-1:0] r_a_mag;
    logic               r_a_neg;
    t_result            r_res;
    logic [IO_BITS-1:0] x_acc, x_vel, x_pos;
    logic [IO_BITS-1:0] y_acc, y_vel, y_pos;

    // Hold the magnitude and sign of the accepted command
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_a_neg <= i_accel_cmd[IO_BITS-1];
            r_a_mag <= i_accel_cmd[IO_BITS-1] ? (~i_accel_cmd + IO_BITS'(1)) : i_accel_cmd;
        end
    end

    tti_lane #(
        .DATA_BITS (DATA_BITS)
    ) u_lane_x (
        .i_clk       (i_clk),
        .i_op        (i_cmd.op),
        .i_a_mag     (r_a_mag),
        .i_a_neg     (r_a_neg),
        .i_coef      (i_cfg.cos_angle),
        .i_half_step (i_cfg.half_step),
        .i_start     (i_cfg.start_x),
        .o_acc       (x_acc),
        .o_vel       (x_vel),
        .o_pos       (x_pos)
    );

    tti_lane #(
        .DATA_BITS (DATA_BITS)
    ) u_lane_y (
        .i_clk       (i_clk),
        .i_op        (i_cmd.op),
        .i_a_mag     (r_a_mag),
        .i_a_neg     (r_a_neg),
        .i_coef      (i_cfg.sin_angle),
        .i_half_step (i_cfg.half_step),
        .i_start     (i_cfg.start_y),
        .o_acc       (y_acc),
        .o_vel       (y_vel),
        .o_pos       (y_pos)
    );

    // Capture the finished item into the output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_res.pos_x <= x_pos;
            r_res.pos_y <= y_pos;
            r_res.pos_z <= i_cfg.start_z;
            r_res.vel_x <= x_vel;
            r_res.vel_y <= y_vel;
            r_res.acc_x <= x_acc;
            r_res.acc_y <= y_acc;
        end
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

>>> src/tti_ctrl.sv
// Controller: steps both lanes through one item and owns the handshakes.
`default_nettype none

module tti_ctrl
    import tti_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire logic i_out_ready,
    output logic      o_out_valid,
    output t_dp_cmd   o_cmd
);

    t_state r_state, n_state;
    logic   r_first, n_first;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_first     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_first     <= n_first;
            r_out_valid <= n_out_valid;
        end
    end

    // Sequence one item and issue datapath commands
    always_comb begin
        n_state        = r_state;
        n_first        = r_first;
        n_out_valid    = r_out_valid & ~i_out_ready;
        o_in_ready     = 1'b0;
        o_cmd.op       = OP_IDLE;
        o_cmd.load_in  = 1'b0;
        o_cmd.load_out = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_ANG_MUL;
                end
            end
            S_ANG_MUL: begin
                o_cmd.op = OP_ANG_MUL;
                n_state  = S_ANG_FIN;
            end
            S_ANG_FIN: begin
                o_cmd.op = OP_ANG_FIN;
                n_state  = r_first ? S_FIRST : S_VEL_PREP;
            end
            S_FIRST: begin
                o_cmd.op = OP_FIRST;
                n_first  = 1'b0;
                n_state  = S_DONE;
            end
            S_VEL_PREP: begin
                o_cmd.op = OP_VEL_PREP;
                n_state  = S_VEL_LO;
            end
            S_VEL_LO: begin
                o_cmd.op = OP_MUL_LO;
                n_state  = S_VEL_HI;
            end
            S_VEL_HI: begin
                o_cmd.op = OP_MUL_HI;
                n_state  = S_VEL_FIN;
            end
            S_VEL_FIN: begin
                o_cmd.op = OP_VEL_FIN;
                n_state  = S_POS_PREP;
            end
            S_POS_PREP: begin
                o_cmd.op = OP_POS_PREP;
                n_state  = S_POS_LO;
            end
            S_POS_LO: begin
                o_cmd.op = OP_MUL_LO;
                n_state  = S_POS_HI;
            end
            S_POS_HI: begin
                o_cmd.op = OP_MUL_HI;
                n_state  = S_POS_FIN;
            end
            S_POS_FIN: begin
                o_cmd.op = OP_POS_FIN;
                n_state  = S_DONE;
            end
            S_DONE: begin
                // Hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

>>> src/trapezoid_target_integrator_core.sv
// Top level of the trapezoid target integrator.
//
//  channel   dir  handshake       payload
//  i_in      in   valid/ready     accel_cmd
//  o_out     out  valid/ready     pos_x pos_y pos_z vel_x vel_y acc_x acc_y
//  apb       in   psel/penable    paddr pwdata -> prdata, pready tied high
//
// An item runs from acceptance to the next acceptance through the sequencer, which
// runs the low and high partial products of each trapezoid step through the one
// multiplier per axis; the first item after reset skips the trapezoid steps.
// Reset is synchronous and active low.
// A stalled output holds the finished item; the block waits in its last step
// until the output register frees, and takes no new item meanwhile.
`default_nettype none

module trapezoid_target_integrator_core
    import tti_pkg::*;
#(
    parameter int DATA_BITS = DATA_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    tti_in_if.sink                    i_in,
    tti_out_if.source                 o_out,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [ADDR_BITS-1:0] paddr,
    input  wire logic [IO_BITS-1:0]   pwdata,
    output logic      [IO_BITS-1:0]   prdata,
    output logic                      pready
);

    t_cfg    cfg;
    t_dp_cmd cmd;
    t_result res;
    logic    in_ready;
    logic    out_valid;

    tti_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    tti_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (in_ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (out_valid),
        .o_cmd       (cmd)
    );

    tti_dp #(
        .DATA_BITS (DATA_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_cmd       (cmd),
        .i_cfg       (cfg),
        .i_accel_cmd (i_in.accel_cmd),
        .o_res       (res)
    );

    // Drive the channels
    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;
    assign o_out.pos_x = res.pos_x;
    assign o_out.pos_y = res.pos_y;
    assign o_out.pos_z = res.pos_z;
    assign o_out.vel_x = res.vel_x;
    assign o_out.vel_y = res.vel_y;
    assign o_out.acc_x = res.acc_x;
    assign o_out.acc_y = res.acc_y;

endmodule

`default_nettype wire
